### hw/rtl/fifo_reader_writer_lock_granter_macros.svh
// ---------------------------------------------------------------------------
// lock granter assertion macros
// clocked concurrent assertion helpers, with and without reset qualification
// ---------------------------------------------------------------------------
`ifndef FIFO_READER_WRITER_LOCK_GRANTER_MACROS_SVH
`define FIFO_READER_WRITER_LOCK_GRANTER_MACROS_SVH

// assertion sampled on clk, disabled while rst_n is low
`define FRLG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on clk, active during reset as well
`define FRLG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/frlg_pkg.sv
// ---------------------------------------------------------------------------
// frlg_pkg
// shared widths, defaults and codes of the reader/writer lock granter
// ---------------------------------------------------------------------------
`default_nettype none

package frlg_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int RANK_BITS_DEF   = 16;

  localparam int RANK_W  = 16;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 17;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  // input action codes
  localparam logic ACT_LOCK   = 1'b0;
  localparam logic ACT_UNLOCK = 1'b1;

  // lock types
  localparam logic LOCK_SHARED = 1'b0;
  localparam logic LOCK_EXCL   = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GRANT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NO_HOLDER = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/frlg_if.sv
// ---------------------------------------------------------------------------
// frlg channel interfaces
// valid/ready channels for lock events and for grant results
// ---------------------------------------------------------------------------
`default_nettype none

interface frlg_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [frlg_pkg::RANK_W-1:0] requester_rank;
  logic                      lock_mode;

  modport source (output valid, output action, output requester_rank,
                  output lock_mode, input ready);
  modport sink   (input valid, input action, input requester_rank,
                  input lock_mode, output ready);
endinterface

interface frlg_res_if;
  logic                        valid;
  logic                        ready;
  logic [frlg_pkg::KIND_W-1:0] result_kind;
  logic [frlg_pkg::RANK_W-1:0] granted_rank;
  logic                        last_of_run;

  modport source (output valid, output result_kind, output granted_rank,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input granted_rank,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/frlg_ram.sv
// ---------------------------------------------------------------------------
// frlg_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module frlg_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fifo_reader_writer_lock_granter.sv
// results: a reject or an unlock without holder is kept in the spec registers
//   and sent from ST_SEND; each grant comes from ST_RD (registered RAM read) and
//   ST_EVAL and is held back until the next grant is decided, the last one sent
//   from ST_FLUSH when the next queue head is blocked or the queue runs empty
// events: no new event is taken until the sequencer is back in ST_IDLE
// reset: synchronous, clears pointers, fill, holder count and kind; RAM kept
// ---------------------------------------------------------------------------
// fifo_reader_writer_lock_granter
// target-side reader/writer lock manager with a fifo wait queue in RAM
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_reader_writer_lock_granter #(
  parameter int QUEUE_DEPTH = frlg_pkg::QUEUE_DEPTH_DEF,
  parameter int RANK_BITS   = frlg_pkg::RANK_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  frlg_req_if.sink        in_req,
  frlg_res_if.source      out_res
);

  import frlg_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = RANK_BITS + 1;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a lock event
  localparam logic [2:0] ST_RD    = 3'd1;  // issue read of the queue head
  localparam logic [2:0] ST_EVAL  = 3'd2;  // head entry available, decide grant
  localparam logic [2:0] ST_FLUSH = 3'd3;  // release held grant as last of run
  localparam logic [2:0] ST_SEND  = 3'd4;  // deliver reject / no-holder result

  logic [2:0]        state_r, state_nxt;

  // queue bookkeeping
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  // holders
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               hkind_r, hkind_nxt;

  // one grant is held back until we know whether another one follows
  logic              pend_valid_r, pend_valid_nxt;
  logic [RANK_W-1:0] pend_rank_r, pend_rank_nxt;

  // special single result (reject or unlock without holder)
  logic [KIND_W-1:0] spec_kind_r, spec_kind_nxt;
  logic [RANK_W-1:0] spec_rank_r, spec_rank_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;
  logic              out_last_r, out_last_nxt;

  // queue RAM ports
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ENT_W-1:0]  ram_rdata;

  logic [RANK_BITS-1:0] rank_in_st;
  logic [RANK_W-1:0]    rank_out;
  logic                 ent_kind;
  logic                 in_acc;
  logic                 out_free;
  logic                 grant_ok;
  logic                 q_full;

  // the rejected rank is reported as stored, i.e. limited to RANK_BITS
  function automatic logic [RANK_W-1:0] rank_out_of_input(
    input logic [RANK_W-1:0] rank
  );
    logic [RANK_W-1:0] mask;
    mask = (RANK_BITS >= RANK_W) ? '1 : RANK_W'((1 << RANK_BITS) - 1);
    return rank & mask;
  endfunction

  // rank width adaptation between the 16-bit field and the stored rank
  if (RANK_BITS < RANK_W) begin : g_rank_narrow
    assign rank_in_st = in_req.requester_rank[RANK_BITS-1:0];
    assign rank_out   = {{(RANK_W - RANK_BITS){1'b0}}, ram_rdata[RANK_BITS-1:0]};
  end else if (RANK_BITS == RANK_W) begin : g_rank_equal
    assign rank_in_st = in_req.requester_rank;
    assign rank_out   = ram_rdata[RANK_W-1:0];
  end else begin : g_rank_wide
    assign rank_in_st = {{(RANK_BITS - RANK_W){1'b0}}, in_req.requester_rank};
    assign rank_out   = ram_rdata[RANK_W-1:0];
  end

  assign ent_kind = ram_rdata[RANK_BITS];

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid & in_req.ready;
  assign out_free     = !out_valid_r || out_res.ready;
  assign q_full       = (fill_r == FILL_FULL);

  // head may be granted when the lock is free or everyone is shared,
  // and the holder count has room left
  assign grant_ok = ((count_r == '0) ||
                     (hkind_r == LOCK_SHARED && ent_kind == LOCK_SHARED)) &&
                    (count_r != COUNT_MAX);

  // queue writes happen at acceptance, reads only later in ST_RD
  assign ram_we    = in_acc && (in_req.action == ACT_LOCK) && !q_full;
  assign ram_wdata = {in_req.lock_mode, rank_in_st};
  assign ram_re    = (state_r == ST_RD) && (fill_r != '0);

  frlg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    count_nxt      = count_r;
    hkind_nxt      = hkind_r;
    pend_valid_nxt = pend_valid_r;
    pend_rank_nxt  = pend_rank_r;
    spec_kind_nxt  = spec_kind_r;
    spec_rank_nxt  = spec_rank_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_kind_nxt   = out_kind_r;
    out_rank_nxt   = out_rank_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req.action == ACT_LOCK) begin
            if (q_full) begin
              spec_kind_nxt = KIND_REJECT;
              spec_rank_nxt = rank_out_of_input(in_req.requester_rank);
              state_nxt     = ST_SEND;
            end else begin
              tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
              fill_nxt  = fill_r + 1'b1;
              state_nxt = ST_RD;
            end
          end else begin
            if (count_r == '0) begin
              spec_kind_nxt = KIND_NO_HOLDER;
              spec_rank_nxt = '0;
              state_nxt     = ST_SEND;
            end else begin
              count_nxt = count_r - 1'b1;
              state_nxt = ST_RD;
            end
          end
        end
      end

      ST_RD: begin
        // empty queue: nothing more to grant
        state_nxt = (fill_r != '0) ? ST_EVAL : ST_FLUSH;
      end

      ST_EVAL: begin
        if (!grant_ok) begin
          state_nxt = ST_FLUSH;
        end else if (!pend_valid_r || out_free) begin
          // a further grant follows, so the held one is not last
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_GRANT;
            out_rank_nxt  = pend_rank_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_rank_nxt  = rank_out;
          head_nxt       = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
          fill_nxt       = fill_r - 1'b1;
          count_nxt      = count_r + 1'b1;
          hkind_nxt      = ent_kind;
          state_nxt      = ST_RD;
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_GRANT;
          out_rank_nxt   = pend_rank_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = spec_kind_r;
          out_rank_nxt  = spec_rank_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      count_r      <= '0;
      hkind_r      <= LOCK_SHARED;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      count_r      <= count_nxt;
      hkind_r      <= hkind_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_rank_r <= pend_rank_nxt;
    spec_kind_r <= spec_kind_nxt;
    spec_rank_r <= spec_rank_nxt;
    out_kind_r  <= out_kind_nxt;
    out_rank_r  <= out_rank_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.result_kind  = out_kind_r;
  assign out_res.granted_rank = out_rank_r;
  assign out_res.last_of_run  = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/frlg_checker.sv
// ---------------------------------------------------------------------------
// frlg_checker
// port-level checks of the lock granter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "fifo_reader_writer_lock_granter_macros.svh"

module frlg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [frlg_pkg::KIND_W-1:0] out_kind,
  input wire logic [frlg_pkg::RANK_W-1:0] out_rank,
  input wire logic                        out_last
);

  import frlg_pkg::*;

  logic out_stall;
  logic out_special;

  assign out_stall   = out_valid && !out_ready;
  assign out_special = out_valid && (out_kind != KIND_GRANT);

  // a stalled transaction keeps its payload
  `FRLG_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_kind) && $stable(out_rank) && $stable(out_last), "result changed while stalled")

  // reject and no-holder results are always a run of one
  `FRLG_ASSERT(a_special_last, out_special |-> out_last, "special result not last of run")

  // an unlock without holder reports rank zero
  `FRLG_ASSERT(a_noholder_rank, (out_valid && out_kind == KIND_NO_HOLDER) |-> (out_rank == '0), "no-holder result with nonzero rank")

  // no new event is taken in the cycle after one was accepted
  `FRLG_ASSERT(a_one_event, (in_valid && in_ready) |=> !in_ready, "back-to-back event acceptance")

endmodule

bind fifo_reader_writer_lock_granter frlg_checker u_frlg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_kind  (out_res.result_kind),
  .out_rank  (out_res.granted_rank),
  .out_last  (out_res.last_of_run)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the fifo reader/writer lock granter: lock and
// unlock events go in through a valid/ready driver, an internal lock table
// predicts every grant, reject and unlock-without-holder result, and a
// monitor checks each result transaction in order, under varied idling
// ---------------------------------------------------------------------------

module tb_top;
  import frlg_pkg::*;

  localparam int QDEPTH        = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int TAIL_CYCLES   = 60;
  localparam int MAX_PRINTS    = 30;

  // one lock event as offered on the input channel
  typedef struct packed {
    logic              action;
    logic [RANK_W-1:0] requester_rank;
    logic              lock_mode;
  } lock_event_t;

  // one result transaction as the granter should produce it
  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [RANK_W-1:0] granted_rank;
    logic              last_of_run;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst_n;

  frlg_req_if lock_ev();
  frlg_res_if lock_res();

  fifo_reader_writer_lock_granter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (lock_ev),
    .out_res (lock_res)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // events waiting to be offered, results waiting to be seen
  lock_event_t  pending_events[$];
  lock_result_t lock_results_due[$];

  // idling knobs, changed by the sequencer between phases
  int send_idle_pct;
  int recv_stall_pct;
  logic holdoff_req;
  int holdoff_left;

  // bookkeeping
  int mismatches     = 0;
  int cycle_count    = 0;
  int events_taken   = 0;
  int grants_seen    = 0;
  int rejects_seen   = 0;
  int no_holder_seen = 0;
  int deepest_fill   = 0;
  int longest_run    = 0;

  // -------------------------------------------------------------------------
  // lock table: our own copy of the wait queue and holder state
  // -------------------------------------------------------------------------
  logic [RANK_W-1:0]  wq_rank [QDEPTH];
  logic               wq_kind [QDEPTH];
  int                 wq_head    = 0;
  int                 wq_tail    = 0;
  int                 wq_fill    = 0;
  logic [COUNT_W-1:0] held_count = '0;
  logic               held_kind  = LOCK_SHARED;

  // apply one accepted event to the lock table and queue the results it causes
  task automatic apply_lock_event(input lock_event_t ev);
    logic [RANK_W-1:0] granted[$];
    lock_result_t      res;
    logic              head_kind;
    int                n;
    if (ev.action == ACT_LOCK) begin
      if (wq_fill == QDEPTH) begin
        // queue full: bounce the request back with its own rank
        res.result_kind  = KIND_REJECT;
        res.granted_rank = ev.requester_rank;
        res.last_of_run  = 1'b1;
        lock_results_due.push_back(res);
        return;
      end
      wq_rank[wq_tail] = ev.requester_rank;
      wq_kind[wq_tail] = ev.lock_mode;
      wq_tail = (wq_tail + 1) % QDEPTH;
      wq_fill++;
      if (wq_fill > deepest_fill) deepest_fill = wq_fill;
    end else begin
      if (held_count == '0) begin
        // unlock with nobody holding: flagged, count stays at zero
        res.result_kind  = KIND_NO_HOLDER;
        res.granted_rank = '0;
        res.last_of_run  = 1'b1;
        lock_results_due.push_back(res);
        return;
      end
      held_count = held_count - 1'b1;
    end
    // walk the queue head while the lock is free or both sides are shared and the count has room
    while (wq_fill > 0) begin
      head_kind = wq_kind[wq_head];
      if (!(held_count == '0 || (held_kind == LOCK_SHARED && head_kind == LOCK_SHARED)))
        break;
      if (held_count >= COUNT_MAX) break;
      granted.push_back(wq_rank[wq_head]);
      held_kind  = head_kind;
      held_count = held_count + 1'b1;
      wq_head = (wq_head + 1) % QDEPTH;
      wq_fill--;
    end
    n = granted.size();
    if (n > longest_run) longest_run = n;
    for (int i = 0; i < n; i++) begin
      res.result_kind  = KIND_GRANT;
      res.granted_rank = granted[i];
      res.last_of_run  = (i == n - 1);
      lock_results_due.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // -------------------------------------------------------------------------
  // driver: offers the pending events, predicts at each accepted transaction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      lock_ev.valid          <= 1'b0;
      lock_ev.action         <= ACT_LOCK;
      lock_ev.requester_rank <= '0;
      lock_ev.lock_mode      <= LOCK_SHARED;
    end else begin
      if (lock_ev.valid && lock_ev.ready) begin
        apply_lock_event(pending_events.pop_front());
        events_taken++;
      end
      // a new offer only once the current one is gone
      if (!lock_ev.valid || lock_ev.ready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          lock_ev.valid          <= 1'b1;
          lock_ev.action         <= pending_events[0].action;
          lock_ev.requester_rank <= pending_events[0].requester_rank;
          lock_ev.lock_mode      <= pending_events[0].lock_mode;
        end else begin
          lock_ev.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // long receiver hold-off, counted here so the monitor just looks at it
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      holdoff_left <= 0;
    end else if (holdoff_req) begin
      holdoff_left <= HOLDOFF_LEN;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // -------------------------------------------------------------------------
  // monitor: checks each result transaction against the oldest prediction
  // -------------------------------------------------------------------------
  lock_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      lock_res.ready <= 1'b0;
    end else begin
      if (lock_res.valid && lock_res.ready) begin
        if (lock_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d rank %h",
                                    lock_res.result_kind, lock_res.granted_rank));
        end else begin
          want = lock_results_due.pop_front();
          if (lock_res.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %0d, want %0d",
                                      lock_res.result_kind, want.result_kind));
          if (lock_res.granted_rank !== want.granted_rank)
            report_mismatch($sformatf("granted_rank %h, want %h",
                                      lock_res.granted_rank, want.granted_rank));
          if (lock_res.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b",
                                      lock_res.last_of_run, want.last_of_run));
          case (want.result_kind)
            KIND_GRANT:  grants_seen++;
            KIND_REJECT: rejects_seen++;
            default:     no_holder_seen++;
          endcase
        end
      end
      lock_res.ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // sequencer helpers, all acting on the falling edge
  // -------------------------------------------------------------------------
  task automatic push_event(input logic act, input logic [RANK_W-1:0] rank,
                            input logic ltype);
    lock_event_t ev;
    ev.action         = act;
    ev.requester_rank = rank;
    ev.lock_mode      = ltype;
    pending_events.push_back(ev);
  endtask

  // random traffic in segments, each with its own lock/unlock and type mix
  task automatic queue_lock_traffic(input int count);
    int seg_left;
    int lock_pct;
    int excl_pct;
    logic [RANK_W-1:0] rank;
    seg_left = 0;
    lock_pct = 50;
    excl_pct = 30;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 3))
          0:       lock_pct = 35;
          1:       lock_pct = 50;
          2:       lock_pct = 70;
          default: lock_pct = 90;
        endcase
        case ($urandom_range(0, 2))
          0:       excl_pct = 10;
          1:       excl_pct = 40;
          default: excl_pct = 80;
        endcase
      end
      seg_left--;
      case ($urandom_range(0, 9))
        0:       rank = '0;
        1:       rank = '1;
        default: rank = RANK_W'($urandom_range(0, 16'hFFFF));
      endcase
      push_event(($urandom_range(0, 99) < lock_pct) ? ACT_LOCK : ACT_UNLOCK, rank,
                 ($urandom_range(0, 99) < excl_pct) ? LOCK_EXCL : LOCK_SHARED);
    end
  endtask

  // sender stays quiet until every predicted result has come back
  task automatic wait_for_drain();
    while (pending_events.size() != 0 || lock_results_due.size() != 0)
      @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  int idle_mix  [4] = '{0, 60, 0, 16};
  int stall_mix [4] = '{0, 0, 60, 16};

  initial begin
    rst_n                  = 1'b0;
    holdoff_req            = 1'b0;
    send_idle_pct          = 0;
    recv_stall_pct         = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: unlock with nobody holding, right out of reset
    push_event(ACT_UNLOCK, 16'h0000, LOCK_SHARED);
    // two shared grants at the rank extremes
    push_event(ACT_LOCK, 16'h0000, LOCK_SHARED);
    push_event(ACT_LOCK, 16'hFFFF, LOCK_SHARED);
    // exclusive waits behind shared holders, shared waits behind it
    push_event(ACT_LOCK, 16'h8001, LOCK_EXCL);
    push_event(ACT_LOCK, 16'h7FFE, LOCK_SHARED);
    // unlock with junk in the ignored fields: no grant yet
    push_event(ACT_UNLOCK, 16'hFFFF, LOCK_EXCL);
    // last holder leaves: exclusive granted, shared head stays blocked
    push_event(ACT_UNLOCK, 16'h0000, LOCK_SHARED);
    // fill the wait queue up behind the exclusive holder
    for (int i = 0; i < QDEPTH - 1; i++)
      push_event(ACT_LOCK, RANK_W'($urandom_range(0, 16'hFFFF)), LOCK_SHARED);
    // full queue: request rejected
    push_event(ACT_LOCK, 16'hBEEF, LOCK_EXCL);
    // exclusive leaves: the whole queue of shared requests granted in one run
    push_event(ACT_UNLOCK, 16'h5A5A, LOCK_SHARED);
    wait_for_drain();

    // random traffic under each idling mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      queue_lock_traffic(100);
      wait_for_drain();
    end

    // receiver holds off a long stretch while events keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 1'b1;
    @(negedge clk);
    holdoff_req    = 1'b0;
    queue_lock_traffic(60);
    wait_for_drain();

    // quiet tail to catch any stray result transaction
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("tb: %0d lock events, %0d grants, %0d queue-full rejects, %0d unlocks without holder",
             events_taken, grants_seen, rejects_seen, no_holder_seen);
    $display("tb: deepest wait queue %0d of %0d, longest grant run %0d, %0d mismatches",
             deepest_fill, QDEPTH, longest_run, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
